>>> rtl/peet_pkg.sv
// ----------------------------------------------------------------------------
// peet_pkg
// Shared types and constants for the periodic event timer table.
// ----------------------------------------------------------------------------
package peet_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int TIME_W       = 40;
  localparam int ADDR_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int OPCODE_W     = 2;
  localparam int READING_W    = 32;
  localparam int SLOT_FIELD_W = 4;
  localparam int PERIOD_W     = 24;
  localparam int COUNT_W      = 16;
  localparam int STEP_W       = 16;

  localparam logic [STEP_W-1:0] DEFAULT_STEP = STEP_W'(1000);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK       = 2'd0,
    OP_REGISTER   = 2'd1,
    OP_UNREGISTER = 2'd2
  } op_e;

  typedef struct packed {
    logic                endless;
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  remaining;
    logic [TIME_W-1:0]   last_time;
  } slot_t;

  localparam int SLOT_ENTRY_W = $bits(slot_t);

endpackage

>>> rtl/periodic_event_timer_table_core.sv
// ----------------------------------------------------------------------------
// periodic_event_timer_table_core
// Table of periodic timer slots driven by a millisecond time base.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one request: a tick, a slot
// register or a slot unregister. Output channel (out_valid_o / out_stall_i)
// delivers one firing report per due slot, in slot order; last_of_run_o marks
// the final report of a tick. The config channel (cfg_valid_i / cfg_ready_o)
// writes the largest clock step; a zero write stores 1000. Write it only
// while the block is idle.
// Register and unregister pass through the execute state before the next
// request can be taken. A tick updates the clock in the execute state, then
// reads the slot memory one entry a cycle while the scan is not paused, with
// the compare and write-back working on the registered read data, then hands
// the held last report to the output register. The single memory port pair
// and the registered read set the pace of the scan. A stalled receiver holds
// the output register; the scan pauses only when a second report is ready and
// the output register is still full, and the final hand-off waits for it.
// Reset clears the clock state, all slot active bits and the output; the slot
// memory itself is not cleared and its contents are used only for active slots.
// ----------------------------------------------------------------------------
module periodic_event_timer_table_core
  import peet_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [STEP_W-1:0]       cfg_max_step_ms_i,

  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OPCODE_W-1:0]     opcode_i,
  input  logic [READING_W-1:0]    counter_reading_i,
  input  logic [SLOT_FIELD_W-1:0] slot_i,
  input  logic [PERIOD_W-1:0]     period_ms_i,
  input  logic [COUNT_W-1:0]      repeat_count_i,
  input  logic                    repeat_forever_i,

  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SLOT_FIELD_W-1:0] fired_slot_o,
  output logic                    retired_o,
  output logic                    last_of_run_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH
  } state_e;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_SLOTS - 1);

  state_e                  state_q, state_d;
  logic [STEP_W-1:0]       max_step_q, max_step_d;
  logic [TIME_W-1:0]       now_q, now_d;
  logic [READING_W-1:0]    prev_q, prev_d;
  logic                    primed_q, primed_d;
  logic [NUM_SLOTS-1:0]    active_q, active_d;

  logic [OPCODE_W-1:0]     op_q, op_d;
  logic [READING_W-1:0]    reading_q, reading_d;
  logic [SLOT_FIELD_W-1:0] slot_q, slot_d;
  logic [PERIOD_W-1:0]     period_q, period_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic                    forever_q, forever_d;

  logic [ADDR_W-1:0]       idx_q, idx_d;
  logic                    issuing_q, issuing_d;
  logic                    ev_valid_q, ev_valid_d;
  logic [ADDR_W-1:0]       ev_idx_q, ev_idx_d;

  logic                    pend_valid_q, pend_valid_d;
  logic [ADDR_W-1:0]       pend_slot_q, pend_slot_d;
  logic                    pend_retired_q, pend_retired_d;

  logic                    out_valid_q, out_valid_d;
  logic [SLOT_FIELD_W-1:0] out_slot_q, out_slot_d;
  logic                    out_retired_q, out_retired_d;
  logic                    out_last_q, out_last_d;

  slot_t                   mem [NUM_SLOTS];
  slot_t                   mem_rdata_q;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  slot_t                   mem_wdata;
  logic                    mem_re;

  logic [READING_W-1:0]    delta;
  logic [READING_W-1:0]    step;
  logic [TIME_W-1:0]       elapsed;
  logic [COUNT_W-1:0]      rem_dec;
  logic                    due;
  logic                    retire;
  logic                    out_free;
  logic                    hold;
  logic                    slot_in_range;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[idx_q];
    end
  end

  always_comb begin
    delta = reading_q - prev_q;
    if (delta[READING_W-1]) begin
      step = '0;
    end else if (delta > READING_W'(max_step_q)) begin
      step = READING_W'(max_step_q);
    end else begin
      step = delta;
    end

    elapsed       = now_q - mem_rdata_q.last_time;
    rem_dec       = mem_rdata_q.remaining - COUNT_W'(1);
    due           = ev_valid_q && active_q[ev_idx_q] &&
                    (elapsed > TIME_W'(mem_rdata_q.period));
    retire        = !mem_rdata_q.endless && (rem_dec == '0);
    out_free      = !out_valid_q || !out_stall_i;
    hold          = due && pend_valid_q && !out_free;
    slot_in_range = (32'(slot_q) < NUM_SLOTS);
  end

  always_comb begin
    state_d        = state_q;
    max_step_d     = max_step_q;
    now_d          = now_q;
    prev_d         = prev_q;
    primed_d       = primed_q;
    active_d       = active_q;
    op_d           = op_q;
    reading_d      = reading_q;
    slot_d         = slot_q;
    period_d       = period_q;
    count_d        = count_q;
    forever_d      = forever_q;
    idx_d          = idx_q;
    issuing_d      = issuing_q;
    ev_valid_d     = ev_valid_q;
    ev_idx_d       = ev_idx_q;
    pend_valid_d   = pend_valid_q;
    pend_slot_d    = pend_slot_q;
    pend_retired_d = pend_retired_q;
    out_valid_d    = out_valid_q;
    out_slot_d     = out_slot_q;
    out_retired_d  = out_retired_q;
    out_last_d     = out_last_q;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = ev_idx_q;
    mem_wdata      = mem_rdata_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      max_step_d = (cfg_max_step_ms_i == '0) ? DEFAULT_STEP : cfg_max_step_ms_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = opcode_i;
          reading_d = counter_reading_i;
          slot_d    = slot_i;
          period_d  = period_ms_i;
          count_d   = repeat_count_i;
          forever_d = repeat_forever_i;
          state_d   = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_IDLE;
        case (op_e'(op_q))
          OP_TICK: begin
            prev_d   = reading_q;
            primed_d = 1'b1;
            if (primed_q) begin
              now_d = now_q + TIME_W'(step);
            end
            idx_d     = '0;
            issuing_d = 1'b1;
            state_d   = S_SCAN;
          end
          OP_REGISTER: begin
            if ((forever_q || count_q != '0) && slot_in_range) begin
              prev_d   = reading_q;
              primed_d = 1'b1;
              if (primed_q) begin
                now_d = now_q + TIME_W'(step);
              end
              mem_we              = 1'b1;
              mem_waddr           = slot_q[ADDR_W-1:0];
              mem_wdata.endless   = forever_q;
              mem_wdata.period    = period_q;
              mem_wdata.remaining = count_q;
              mem_wdata.last_time = now_d;
              active_d[slot_q[ADDR_W-1:0]] = 1'b1;
            end
          end
          OP_UNREGISTER: begin
            if (slot_in_range) begin
              active_d[slot_q[ADDR_W-1:0]] = 1'b0;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        if (!hold) begin
          // read stage
          if (issuing_q) begin
            mem_re = 1'b1;
            idx_d  = idx_q + ADDR_W'(1);
            if (idx_q == LAST_IDX) begin
              issuing_d = 1'b0;
            end
          end
          ev_valid_d = issuing_q;
          ev_idx_d   = idx_q;

          // compare and write-back stage
          if (due) begin
            mem_we              = 1'b1;
            mem_waddr           = ev_idx_q;
            mem_wdata.last_time = mem_rdata_q.last_time + TIME_W'(mem_rdata_q.period);
            if (!mem_rdata_q.endless) begin
              mem_wdata.remaining = rem_dec;
            end
            if (retire) begin
              active_d[ev_idx_q] = 1'b0;
            end
            if (pend_valid_q) begin
              out_valid_d   = 1'b1;
              out_slot_d    = SLOT_FIELD_W'(pend_slot_q);
              out_retired_d = pend_retired_q;
              out_last_d    = 1'b0;
            end
            pend_valid_d   = 1'b1;
            pend_slot_d    = ev_idx_q;
            pend_retired_d = retire;
          end

          if (!issuing_q && !ev_valid_q) begin
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d   = 1'b1;
          out_slot_d    = SLOT_FIELD_W'(pend_slot_q);
          out_retired_d = pend_retired_q;
          out_last_d    = 1'b1;
          pend_valid_d  = 1'b0;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      max_step_q     <= DEFAULT_STEP;
      now_q          <= '0;
      prev_q         <= '0;
      primed_q       <= 1'b0;
      active_q       <= '0;
      op_q           <= '0;
      reading_q      <= '0;
      slot_q         <= '0;
      period_q       <= '0;
      count_q        <= '0;
      forever_q      <= 1'b0;
      idx_q          <= '0;
      issuing_q      <= 1'b0;
      ev_valid_q     <= 1'b0;
      ev_idx_q       <= '0;
      pend_valid_q   <= 1'b0;
      pend_slot_q    <= '0;
      pend_retired_q <= 1'b0;
      out_valid_q    <= 1'b0;
      out_slot_q     <= '0;
      out_retired_q  <= 1'b0;
      out_last_q     <= 1'b0;
    end else begin
      state_q        <= state_d;
      max_step_q     <= max_step_d;
      now_q          <= now_d;
      prev_q         <= prev_d;
      primed_q       <= primed_d;
      active_q       <= active_d;
      op_q           <= op_d;
      reading_q      <= reading_d;
      slot_q         <= slot_d;
      period_q       <= period_d;
      count_q        <= count_d;
      forever_q      <= forever_d;
      idx_q          <= idx_d;
      issuing_q      <= issuing_d;
      ev_valid_q     <= ev_valid_d;
      ev_idx_q       <= ev_idx_d;
      pend_valid_q   <= pend_valid_d;
      pend_slot_q    <= pend_slot_d;
      pend_retired_q <= pend_retired_d;
      out_valid_q    <= out_valid_d;
      out_slot_q     <= out_slot_d;
      out_retired_q  <= out_retired_d;
      out_last_q     <= out_last_d;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign fired_slot_o  = out_slot_q;
  assign retired_o     = out_retired_q;
  assign last_of_run_o = out_last_q;

endmodule

>>> verif/periodic_event_timer_table_checker.sv
// ----------------------------------------------------------------------------
// periodic_event_timer_table_checker
// Watches the request, firing-report and step-limit channels of the timer
// table. Each accepted request is run through a cycle-free model of the slot
// table and clock base, which queues the firing reports it should cause. Each
// accepted report is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module periodic_event_timer_table_checker
  import peet_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [STEP_W-1:0]       cfg_max_step_ms_i,

  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [OPCODE_W-1:0]     opcode_i,
  input  logic [READING_W-1:0]    counter_reading_i,
  input  logic [SLOT_FIELD_W-1:0] slot_i,
  input  logic [PERIOD_W-1:0]     period_ms_i,
  input  logic [COUNT_W-1:0]      repeat_count_i,
  input  logic                    repeat_forever_i,

  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [SLOT_FIELD_W-1:0] fired_slot_i,
  input  logic                    retired_i,
  input  logic                    last_of_run_i,

  output int                      error_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    retired;
    logic                    closes_run;
  } fire_report_t;

  logic [STEP_W-1:0]    step_limit;
  logic [TIME_W-1:0]    time_acc;
  logic [READING_W-1:0] last_reading;
  logic                 reading_seen;
  logic [NUM_SLOTS-1:0] slot_on;
  logic                 slot_endless [NUM_SLOTS];
  logic [PERIOD_W-1:0]  slot_per     [NUM_SLOTS];
  logic [TIME_W-1:0]    slot_base    [NUM_SLOTS];
  logic [COUNT_W-1:0]   slot_left    [NUM_SLOTS];
  fire_report_t         fire_q[$];

  initial error_count_o = 0;

  task automatic report_mismatch(input string what);
    if (error_count_o < PRINT_CAP) begin
      $display("%0t checker: %s", $realtime, what);
    end
    error_count_o++;
  endtask

  // wrapped delta, negative steps count as zero, large steps are clipped
  task automatic step_clock(input logic [READING_W-1:0] reading);
    logic [READING_W-1:0] delta;
    if (!reading_seen) begin
      reading_seen = 1'b1;
      last_reading = reading;
    end else begin
      delta = reading - last_reading;
      if (delta[READING_W-1]) begin
        delta = '0;
      end
      if (delta > READING_W'(step_limit)) begin
        delta = READING_W'(step_limit);
      end
      last_reading = reading;
      time_acc     = time_acc + TIME_W'(delta);
    end
  endtask

  task automatic predict_request();
    logic [SLOT_FIELD_W-1:0] hit_slot [NUM_SLOTS];
    logic                    hit_ret  [NUM_SLOTS];
    logic [TIME_W-1:0]       elapsed;
    int                      hits;
    hits = 0;
    case (opcode_i)
      OP_TICK: begin
        step_clock(counter_reading_i);
        for (int i = 0; i < NUM_SLOTS; i++) begin
          elapsed = time_acc - slot_base[i];
          if (slot_on[i] && elapsed > TIME_W'(slot_per[i])) begin
            slot_base[i]   = slot_base[i] + TIME_W'(slot_per[i]);
            hit_slot[hits] = SLOT_FIELD_W'(i);
            hit_ret[hits]  = 1'b0;
            if (!slot_endless[i]) begin
              slot_left[i] = slot_left[i] - COUNT_W'(1);
              if (slot_left[i] == '0) begin
                slot_on[i]    = 1'b0;
                hit_ret[hits] = 1'b1;
              end
            end
            hits++;
          end
        end
        for (int k = 0; k < hits; k++) begin
          fire_q.push_back(fire_report_t'{hit_slot[k], hit_ret[k], k == hits - 1});
        end
      end
      OP_REGISTER: begin
        if (repeat_forever_i || repeat_count_i != '0) begin
          step_clock(counter_reading_i);
          slot_on[slot_i]      = 1'b1;
          slot_endless[slot_i] = repeat_forever_i;
          slot_per[slot_i]     = period_ms_i;
          slot_left[slot_i]    = repeat_count_i;
          slot_base[slot_i]    = time_acc;
        end
      end
      OP_UNREGISTER: begin
        slot_on[slot_i] = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fire_report_t want;
    if (!rst_ni) begin
      step_limit   = DEFAULT_STEP;
      time_acc     = '0;
      last_reading = '0;
      reading_seen = 1'b0;
      slot_on      = '0;
      fire_q.delete();
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        step_limit = (cfg_max_step_ms_i == '0) ? DEFAULT_STEP : cfg_max_step_ms_i;
      end
      if (in_valid_i && !in_stall_i) begin
        predict_request();
      end
      if (out_valid_i && !out_stall_i) begin
        if (fire_q.size() == 0) begin
          report_mismatch($sformatf("unexpected report, slot %0d", fired_slot_i));
        end else begin
          want = fire_q.pop_front();
          if (fired_slot_i !== want.slot) begin
            report_mismatch($sformatf("fired_slot %0d, want %0d", fired_slot_i, want.slot));
          end
          if (retired_i !== want.retired) begin
            report_mismatch($sformatf("retired %0b, want %0b (slot %0d)",
                                      retired_i, want.retired, want.slot));
          end
          if (last_of_run_i !== want.closes_run) begin
            report_mismatch($sformatf("last_of_run %0b, want %0b (slot %0d)",
                                      last_of_run_i, want.closes_run, want.slot));
          end
        end
      end
      pending_o = fire_q.size();
    end
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the timer table testbench. Drives directed and random requests with
// random gaps and output stalls, moves the clock step limit through several
// values between phases, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import peet_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_IDLE       = 14;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RAND_PER_PHASE = 56;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [STEP_W-1:0]       cfg_max_step_ms_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OPCODE_W-1:0]     opcode_i;
  logic [READING_W-1:0]    counter_reading_i;
  logic [SLOT_FIELD_W-1:0] slot_i;
  logic [PERIOD_W-1:0]     period_ms_i;
  logic [COUNT_W-1:0]      repeat_count_i;
  logic                    repeat_forever_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [SLOT_FIELD_W-1:0] fired_slot_o;
  logic                    retired_o;
  logic                    last_of_run_o;

  int                      error_count;
  int                      pending;
  int                      quiet_cycles;
  int                      send_burst;
  int                      recv_burst;
  int                      step_now;
  logic [READING_W-1:0]    rd_base;
  logic [STEP_W-1:0]       step_plan [5];

  periodic_event_timer_table_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_max_step_ms_i (cfg_max_step_ms_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .counter_reading_i (counter_reading_i),
    .slot_i            (slot_i),
    .period_ms_i       (period_ms_i),
    .repeat_count_i    (repeat_count_i),
    .repeat_forever_i  (repeat_forever_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .fired_slot_o      (fired_slot_o),
    .retired_o         (retired_o),
    .last_of_run_o     (last_of_run_o)
  );

  periodic_event_timer_table_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_max_step_ms_i (cfg_max_step_ms_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .opcode_i          (opcode_i),
    .counter_reading_i (counter_reading_i),
    .slot_i            (slot_i),
    .period_ms_i       (period_ms_i),
    .repeat_count_i    (repeat_count_i),
    .repeat_forever_i  (repeat_forever_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .fired_slot_i      (fired_slot_o),
    .retired_i         (retired_o),
    .last_of_run_i     (last_of_run_o),
    .error_count_o     (error_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver stalls a random number of cycles ahead of each report
  initial begin
    int hold;
    out_stall_i = 1'b1;
    recv_burst  = 0;
    @(posedge rst_ni);
    forever begin
      if (recv_burst > 0) begin
        recv_burst--;
        hold = 0;
      end else begin
        hold = $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 15) == 0) begin
          recv_burst = $urandom_range(8, 24);
        end
      end
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [READING_W-1:0] reading,
                          input logic [SLOT_FIELD_W-1:0] slot, input logic [PERIOD_W-1:0] period,
                          input logic [COUNT_W-1:0] count, input logic endless);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_IDLE);
      if ($urandom_range(0, 15) == 0) begin
        send_burst = $urandom_range(8, 24);
      end
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= op;
    counter_reading_i <= reading;
    slot_i            <= slot;
    period_ms_i       <= period;
    repeat_count_i    <= count;
    repeat_forever_i  <= endless;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic random_req();
    int                   pick;
    int                   sel;
    logic [OPCODE_W-1:0]  op;
    logic [READING_W-1:0] reading;
    logic [PERIOD_W-1:0]  period;
    logic [COUNT_W-1:0]   count;
    logic                 endless;
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      op = OP_TICK;
    end else if (pick < 82) begin
      op = OP_REGISTER;
    end else if (pick < 96) begin
      op = OP_UNREGISTER;
    end else begin
      op = OP_UNUSED;
    end
    sel = $urandom_range(0, 31);
    if (sel == 0) begin
      reading = $urandom;
    end else if (sel == 1) begin
      reading = rd_base - $urandom_range(1, 5000);
    end else if (sel == 2) begin
      reading = rd_base + $urandom_range(step_now, 4 * step_now + 1);
    end else begin
      reading = rd_base + $urandom_range(0, step_now);
    end
    if (op == OP_TICK || op == OP_REGISTER) begin
      rd_base = reading;
    end else begin
      reading = $urandom;
    end
    if ($urandom_range(0, 15) == 0) begin
      period = PERIOD_W'($urandom);
    end else begin
      period = PERIOD_W'($urandom_range(1, 3 * step_now));
    end
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      count   = '0;
      endless = 1'b0;
    end else if (sel == 1) begin
      count   = COUNT_W'($urandom);
      endless = 1'b0;
    end else if (sel <= 3) begin
      count   = COUNT_W'($urandom);
      endless = 1'b1;
    end else begin
      count   = COUNT_W'($urandom_range(1, 4));
      endless = 1'b0;
    end
    send_req(op, reading, SLOT_FIELD_W'($urandom), period, count, endless);
  endtask

  // drop valid, drain expected reports, then give the scan time to finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_step_limit(input logic [STEP_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_max_step_ms_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    step_now = (value == '0) ? 1000 : int'(value);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_max_step_ms_i = '0;
    in_valid_i        = 1'b0;
    opcode_i          = OP_TICK;
    counter_reading_i = '0;
    slot_i            = '0;
    period_ms_i       = '0;
    repeat_count_i    = '0;
    repeat_forever_i  = 1'b0;
    quiet_cycles      = 0;
    send_burst        = 0;
    step_now          = 1000;
    rd_base           = $urandom;
    step_plan         = '{16'd1, 16'hFFFF, 16'd0, STEP_W'($urandom_range(1, 65535)), 16'd40};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_step_limit(16'd1000);

    // zero-count register, which is ignored, then priming tick
    send_req(OP_REGISTER, rd_base, 4'd3, 24'd50, 16'd0, 1'b0);
    send_req(OP_TICK, rd_base, 4'd0, 24'd0, 16'd0, 1'b0);
    // zero period, widest fields, short one-shot
    send_req(OP_REGISTER, rd_base + 5, 4'd0, 24'd0, 16'd2, 1'b0);
    send_req(OP_REGISTER, rd_base + 5, 4'd15, 24'hFFFFFF, 16'hFFFF, 1'b1);
    send_req(OP_REGISTER, rd_base + 6, 4'd5, 24'd10, 16'd1, 1'b0);
    // clipped step, then a backward reading
    send_req(OP_TICK, rd_base + 3006, 4'd0, 24'd0, 16'd0, 1'b0);
    send_req(OP_TICK, rd_base + 2000, 4'd0, 24'd0, 16'd0, 1'b0);
    // overwrite an active slot, unregister a free one, unused opcode
    send_req(OP_REGISTER, rd_base + 2000, 4'd15, 24'd1, 16'd1, 1'b0);
    send_req(OP_UNREGISTER, $urandom, 4'd5, 24'hFFFFFF, 16'hFFFF, 1'b1);
    send_req(OP_UNUSED, $urandom, 4'd9, 24'd1, 16'd1, 1'b1);
    // counter wrap
    send_req(OP_REGISTER, 32'hFFFF_FFF0, 4'd7, 24'd3, 16'd2, 1'b0);
    send_req(OP_TICK, 32'h0000_0010, 4'd0, 24'd0, 16'd0, 1'b0);
    send_req(OP_UNREGISTER, 32'hFFFF_FFFF, 4'd7, 24'd0, 16'd0, 1'b0);
    send_req(OP_UNREGISTER, 32'h0, 4'd10, 24'd0, 16'd0, 1'b0);
    send_req(OP_TICK, 32'h0000_0010 + 1000, 4'd0, 24'd0, 16'd0, 1'b0);
    send_req(OP_REGISTER, 32'h0000_0400, 4'd9, 24'hFFFFFF, 16'hFFFF, 1'b0);
    send_req(OP_TICK, 32'h0000_0800, 4'd0, 24'd0, 16'd0, 1'b0);
    rd_base = 32'h0000_0800;

    foreach (step_plan[p]) begin
      settle();
      write_step_limit(step_plan[p]);
      repeat (RAND_PER_PHASE) random_req();
    end
    settle();

    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
